FILE: src/pep_pkg.sv
// Shared types, codes and helpers for the pattern pulse event timer.
// Used by pep_store, pep_core and the top level; depends on nothing.
`default_nettype none

package pep_pkg;

    localparam int PATTERN_DEPTH_DEF = 16;
    localparam int TIME_WIDTH_DEF    = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_W     = 16;
    localparam int LIMIT_W     = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Item function codes.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_ARM   = 2'd2;

    // Timer modes.
    localparam logic [1:0] MODE_PERIODIC  = 2'd0;
    localparam logic [1:0] MODE_PATTERN   = 2'd1;
    localparam logic [1:0] MODE_OSCILLATE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_LIMIT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LEVEL  = 2'd3;

    localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RESET = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        start_period;
        logic [LIMIT_W-1:0] repeat_limit;
        logic               start_level;
    } cfg_t;

    typedef struct packed {
        logic [31:0] entry_value;
        logic [3:0]  entry_index;
        logic [1:0]  func;
    } item_t;

    typedef struct packed {
        logic running;
        logic pin_level;
        logic fired;
    } result_t;

    // A negative limit runs forever; otherwise stop once the count reaches it.
    function automatic logic limit_hit(input logic [COUNT_W-1:0] cnt,
                                       input logic [LIMIT_W-1:0] lim);
        limit_hit = !lim[LIMIT_W-1] && (cnt >= lim[COUNT_W-1:0]);
    endfunction

endpackage

`default_nettype wire

FILE: src/pep_store.sv
// Pattern store: a one-port-write, one-port-read synchronous memory with a
// prefetch of the entry after the current position. Uses pep_pkg.
`default_nettype none

module pep_store #(
    parameter int PATTERN_DEPTH = pep_pkg::PATTERN_DEPTH_DEF,
    parameter int TIME_WIDTH    = pep_pkg::TIME_WIDTH_DEF,
    localparam int POS_W        = $clog2(PATTERN_DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [POS_W-1:0]      wr_addr,
    input  wire logic [TIME_WIDTH-1:0] wr_data,
    input  wire logic [POS_W-1:0]      pos_next,
    output logic      [TIME_WIDTH-1:0] next_entry,
    output logic      [TIME_WIDTH-1:0] first_entry
);

    logic [TIME_WIDTH-1:0] mem [PATTERN_DEPTH];
    logic [TIME_WIDTH-1:0] rd_data_reg;
    logic [TIME_WIDTH-1:0] fwd_data_reg;
    logic [TIME_WIDTH-1:0] first_reg;
    logic                  fwd_reg;
    logic                  beyond_reg;
    logic [POS_W:0]        rd_idx;
    logic [POS_W-1:0]      rd_addr;
    logic                  in_range;

    // The entry after the position the core will hold next cycle.
    assign rd_idx   = {1'b0, pos_next} + {{POS_W{1'b0}}, 1'b1};
    assign rd_addr  = rd_idx[POS_W-1:0];
    assign in_range = rd_idx < (POS_W+1)'(PATTERN_DEPTH);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_data;
        if (wr_en && (wr_addr == '0)) begin
            first_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg    <= 1'b0;
            beyond_reg <= 1'b0;
        end else begin
            fwd_reg    <= wr_en && (wr_addr == rd_addr);
            beyond_reg <= !in_range;
        end
    end

    // Past the end of the store reads as a terminating zero entry.
    assign next_entry  = beyond_reg ? '0 : (fwd_reg ? fwd_data_reg : rd_data_reg);
    assign first_entry = first_reg;

endmodule

`default_nettype wire

FILE: src/pep_core.sv
// Timer state and per-item update: tick counting, mode actions, repeat
// limit and arming. Uses pep_pkg; pattern entries come from pep_store.
`default_nettype none

module pep_core #(
    parameter int PATTERN_DEPTH = pep_pkg::PATTERN_DEPTH_DEF,
    parameter int TIME_WIDTH    = pep_pkg::TIME_WIDTH_DEF,
    localparam int POS_W        = $clog2(PATTERN_DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire pep_pkg::item_t        item,
    input  wire pep_pkg::cfg_t         cfg,
    input  wire logic [TIME_WIDTH-1:0] next_entry,
    input  wire logic [TIME_WIDTH-1:0] first_entry,
    output logic                       wr_en,
    output logic      [POS_W-1:0]      wr_addr,
    output logic      [TIME_WIDTH-1:0] wr_data,
    output logic      [POS_W-1:0]      pos_next,
    output pep_pkg::result_t           res
);

    localparam int IW = ((POS_W > 4) ? POS_W : 4) + 1;

    logic                        active_reg, active_next;
    logic [TIME_WIDTH-1:0]       elapsed_reg, elapsed_next;
    logic [TIME_WIDTH-1:0]       period_reg, period_next;
    logic [pep_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]            pos_reg;
    logic                        pin_state_reg, pin_state_next;
    logic                        pin_driven_reg, pin_driven_next;

    logic [TIME_WIDTH-1:0]       el1;
    logic [pep_pkg::COUNT_W-1:0] count_inc;
    logic [IW-1:0]               idx_w;
    logic [TIME_WIDTH+31:0]      val_wide;
    logic [TIME_WIDTH+31:0]      sp_wide;
    logic [TIME_WIDTH-1:0]       sp_w;
    logic                        fired;

    assign idx_w    = IW'(item.entry_index);
    assign val_wide = {{TIME_WIDTH{1'b0}}, item.entry_value};
    assign sp_wide  = {{TIME_WIDTH{1'b0}}, cfg.start_period};
    assign sp_w     = sp_wide[TIME_WIDTH-1:0];
    assign wr_addr  = idx_w[POS_W-1:0];
    assign wr_data  = val_wide[TIME_WIDTH-1:0];
    assign el1      = elapsed_reg + TIME_WIDTH'(1);
    assign count_inc = (count_reg != pep_pkg::COUNT_MAX) ?
                       count_reg + pep_pkg::COUNT_W'(1) : count_reg;

    always_comb begin
        active_next     = active_reg;
        elapsed_next    = elapsed_reg;
        period_next     = period_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        pin_state_next  = pin_state_reg;
        pin_driven_next = pin_driven_reg;
        fired           = 1'b0;
        wr_en           = 1'b0;
        if (accept) begin
            case (item.func)
                pep_pkg::FUNC_TICK: begin
                    if (active_reg) begin
                        elapsed_next = el1;
                        if (el1 >= period_reg) begin
                            elapsed_next = '0;
                            case (cfg.mode)
                                pep_pkg::MODE_PERIODIC: begin
                                    fired      = 1'b1;
                                    count_next = count_inc;
                                end
                                pep_pkg::MODE_PATTERN: begin
                                    if (next_entry == '0) begin
                                        // End of a pass: count it, then wrap
                                        // unless the limit stops the run.
                                        count_next = count_inc;
                                        if (!pep_pkg::limit_hit(count_inc,
                                                                cfg.repeat_limit)) begin
                                            pos_next        = '0;
                                            period_next     = first_entry;
                                            pin_state_next  = !pin_state_reg;
                                            pin_driven_next = !pin_state_reg;
                                        end
                                    end else begin
                                        pos_next        = pos_reg + POS_W'(1);
                                        period_next     = next_entry;
                                        pin_state_next  = !pin_state_reg;
                                        pin_driven_next = !pin_state_reg;
                                    end
                                end
                                pep_pkg::MODE_OSCILLATE: begin
                                    pin_state_next  = !pin_state_reg;
                                    pin_driven_next = !pin_state_reg;
                                    count_next      = count_inc;
                                end
                                default: begin
                                    count_next = count_inc;
                                end
                            endcase
                        end
                        if (pep_pkg::limit_hit(count_next, cfg.repeat_limit)) begin
                            // Run finished: pin_driven keeps its last level.
                            active_next    = 1'b0;
                            elapsed_next   = '0;
                            period_next    = '0;
                            count_next     = '0;
                            pos_next       = '0;
                            pin_state_next = 1'b0;
                        end
                    end
                end
                pep_pkg::FUNC_WRITE: begin
                    wr_en = idx_w < IW'(PATTERN_DEPTH);
                end
                pep_pkg::FUNC_ARM: begin
                    active_next     = 1'b1;
                    elapsed_next    = '0;
                    count_next      = '0;
                    pos_next        = '0;
                    pin_state_next  = cfg.start_level;
                    pin_driven_next = cfg.start_level;
                    period_next     = (cfg.mode == pep_pkg::MODE_PATTERN) ?
                                      first_entry : sp_w;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            elapsed_reg    <= '0;
            period_reg     <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            pin_state_reg  <= 1'b0;
            pin_driven_reg <= 1'b0;
        end else begin
            active_reg     <= active_next;
            elapsed_reg    <= elapsed_next;
            period_reg     <= period_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            pin_state_reg  <= pin_state_next;
            pin_driven_reg <= pin_driven_next;
        end
    end

    assign res.fired     = fired;
    assign res.pin_level = pin_driven_next;
    assign res.running   = active_next;

endmodule

`default_nettype wire

FILE: src/pattern_pulse_event_timer.sv
// Pattern pulse event timer, top level: stream ports, configuration
// registers and a two-entry output queue. Uses pep_pkg, pep_core, pep_store.
// An item's result is registered in the head or, if the head waits, the skid.
// Throughput: one item per cycle while the output queue has room; the
// read of the pattern store is prefetched a step ahead.
// Reset clears the timer and the configuration; the pattern store is not
// cleared and needs no clearing pass, so items are taken right after reset.
`default_nettype none

module pattern_pulse_event_timer #(
    parameter int PATTERN_DEPTH = pep_pkg::PATTERN_DEPTH_DEF,
    parameter int TIME_WIDTH    = pep_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input items.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: func [1:0], entry_index [5:2], entry_value [37:6], zeros above.
    input  wire logic [pep_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Result items.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: fired [0], pin_level [1], running [2], zeros above.
    output logic      [pep_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pep_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pep_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int POS_W = $clog2(PATTERN_DEPTH);

    pep_pkg::cfg_t    cfg_reg;
    pep_pkg::item_t   item;
    pep_pkg::result_t res;
    pep_pkg::result_t out_reg;
    pep_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_accept;
    logic             out_pop;

    logic                  wr_en;
    logic [POS_W-1:0]      wr_addr;
    logic [TIME_WIDTH-1:0] wr_data;
    logic [POS_W-1:0]      pos_next;
    logic [TIME_WIDTH-1:0] next_entry;
    logic [TIME_WIDTH-1:0] first_entry;

    // Configuration registers take a write every cycle out of reset; software
    // must write them only while the timer has no item in flight; not checked.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= pep_pkg::MODE_PERIODIC;
            cfg_reg.start_period <= '0;
            cfg_reg.repeat_limit <= pep_pkg::REPEAT_LIMIT_RESET;
            cfg_reg.start_level  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pep_pkg::CFG_MODE:         cfg_reg.mode         <= cfg_data[1:0];
                pep_pkg::CFG_START_PERIOD: cfg_reg.start_period <= cfg_data;
                pep_pkg::CFG_REPEAT_LIMIT: begin
                    cfg_reg.repeat_limit <= cfg_data[pep_pkg::LIMIT_W-1:0];
                end
                pep_pkg::CFG_START_LEVEL:  cfg_reg.start_level  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign item      = s_tdata[$bits(pep_pkg::item_t)-1:0];
    assign in_accept = s_tvalid && s_tready;
    assign out_pop   = out_valid_reg && m_tready;

    // The skid entry lets an item be taken while the head result waits;
    // input stalls only when both entries hold results, and during reset.
    assign s_tready = aresetn && !skid_valid_reg;

    pep_core #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (in_accept),
        .item        (item),
        .cfg         (cfg_reg),
        .next_entry  (next_entry),
        .first_entry (first_entry),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .pos_next    (pos_next),
        .res         (res)
    );

    pep_store #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .pos_next    (pos_next),
        .next_entry  (next_entry),
        .first_entry (first_entry)
    );

    // Output queue: head register plus one skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_pop || !out_valid_reg) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= in_accept;
                end else begin
                    out_valid_reg  <= in_accept;
                end
            end else if (in_accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (in_accept) begin
                    skid_reg <= res;
                end
            end else begin
                out_reg <= res;
            end
        end else if (in_accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pep_pkg::OUT_TDATA_W - $bits(pep_pkg::result_t)){1'b0}}, out_reg};

    // A result waiting in the skid entry implies the head is also occupied.
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the head is empty");

    // The skid entry fills only when the head was held by a stalled output.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled while the head could move");

    // Only a tick in periodic mode raises the fired flag.
    a_fired_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && res.fired) |->
            (item.func == pep_pkg::FUNC_TICK && cfg_reg.mode == pep_pkg::MODE_PERIODIC))
        else $error("fired flag raised outside a periodic tick");

endmodule

`default_nettype wire
